// ----- rtl/trusted_proxy_chain_resolver_defines.svh -----
// ----------------------------------------------------------------------------
// Trusted proxy chain resolver assertion macros
// Shared assertion forms for the resolver RTL, checked on the rising clock
// edge and held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TRUSTED_PROXY_CHAIN_RESOLVER_DEFINES_SVH
`define TRUSTED_PROXY_CHAIN_RESOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trusted proxy chain resolver: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trusted proxy chain resolver: next-cycle check failed");

`endif

// ----- rtl/tpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Trusted proxy chain resolver package
// Shared constants, request codes and the network table entry type.
// ----------------------------------------------------------------------------
package tpcr_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_HOPS_DEF      = 64;

    localparam int ADDR_W   = 128;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int PREFIX_W = 8;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_HOP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PREFIX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HOPS   = 2'd2;

    localparam logic [PREFIX_W-1:0] V4_PREFIX_MAX = 8'd32;
    localparam logic [PREFIX_W-1:0] V6_PREFIX_MAX = 8'd128;

    typedef struct packed {
        logic              v6;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } t_net;

endpackage

// ----- rtl/tpcr_lookup.sv -----
// ----------------------------------------------------------------------------
// Trusted network lookup
// Compares one address against every table slot in parallel and reports
// whether any enabled slot of the same family matches its masked prefix.
// ----------------------------------------------------------------------------
module tpcr_lookup #(
    parameter int TABLE_ENTRIES = tpcr_pkg::TABLE_ENTRIES_DEF
) (
    input  tpcr_pkg::t_net                i_net [TABLE_ENTRIES],
    input  logic [TABLE_ENTRIES-1:0]      i_net_valid,
    input  logic                          i_v6,
    input  logic [tpcr_pkg::ADDR_W-1:0]   i_addr,
    output logic                          o_hit
);

    logic [TABLE_ENTRIES-1:0] slot_hit;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_hit[i] = i_net_valid[i] && (i_net[i].v6 == i_v6) &&
                          (((i_net[i].addr ^ i_addr) & i_net[i].mask) == '0);
        end
    end

    assign o_hit = |slot_hit;

endmodule

// ----- rtl/trusted_proxy_chain_resolver.sv -----
// ----------------------------------------------------------------------------
// Trusted proxy chain resolver
// Resolves the client address of a forwarded chain against a table of
// trusted IPv4/IPv6 networks.
// ----------------------------------------------------------------------------
// Each accepted request is captured in an input register and fully resolved from
// there, where all table slots are compared with the request address in
// parallel and the walk state and network table are updated. The response lands
// in the output register at the edge that retires the request from the input
// register. One request per cycle is sustained as long as the output side does
// not stall. Load requests always give a response; start and hop requests give
// one only when marked last, a hop only while a walk is active; other action
// codes give none.
`include "trusted_proxy_chain_resolver_defines.svh"

module trusted_proxy_chain_resolver #(
    parameter int TABLE_ENTRIES = tpcr_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_HOPS      = tpcr_pkg::MAX_HOPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tpcr_pkg::ACTION_W-1:0]   i_action,
    input  logic [tpcr_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic                            i_entry_valid,
    input  logic                            i_is_v6,
    input  logic [63:0]                     i_address_high,
    input  logic [63:0]                     i_address_low,
    input  logic [tpcr_pkg::PREFIX_W-1:0]   i_prefix_length,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tpcr_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_client_is_v6,
    output logic [63:0]                     o_client_high,
    output logic [63:0]                     o_client_low,
    output logic                            o_used_forwarded,
    output logic                            o_peer_trusted
);

    localparam int HOP_W = $clog2(MAX_HOPS + 2);
    localparam logic [HOP_W-1:0] HOP_LIMIT = HOP_W'(MAX_HOPS);

    // Input register.
    logic                            r_in_valid;
    logic [tpcr_pkg::ACTION_W-1:0]   r_in_action;
    logic [tpcr_pkg::INDEX_W-1:0]    r_in_index;
    logic                            r_in_entry_valid;
    logic                            r_in_v6;
    logic [tpcr_pkg::ADDR_W-1:0]     r_in_addr;
    logic [tpcr_pkg::PREFIX_W-1:0]   r_in_prefix;
    logic                            r_in_last;

    // Network table.
    tpcr_pkg::t_net                  r_net [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]        r_net_valid;

    // Walk state.
    logic [tpcr_pkg::ADDR_W-1:0]     r_cur_addr, n_cur_addr;
    logic                            r_cur_v6, n_cur_v6;
    logic                            r_walk_active, n_walk_active;
    logic                            r_walk_stopped, n_walk_stopped;
    logic                            r_start_trusted, n_start_trusted;
    logic [HOP_W-1:0]                r_hop_count, n_hop_count;

    // Output register.
    logic                            r_out_valid;
    logic [tpcr_pkg::STATUS_W-1:0]   r_out_status;
    logic                            r_out_v6;
    logic [tpcr_pkg::ADDR_W-1:0]     r_out_addr;
    logic                            r_out_used_forwarded;
    logic                            r_out_peer_trusted;

    logic                            out_free;
    logic                            advance;
    logic                            accept;
    logic                            hit;
    logic                            index_in_range;
    logic                            load_write;
    logic                            load_clear;
    logic                            close_walk;
    logic                            emit;
    logic [tpcr_pkg::STATUS_W-1:0]   res_status;
    logic                            res_v6;
    logic [tpcr_pkg::ADDR_W-1:0]     res_addr;
    logic                            res_used_forwarded;
    logic                            res_peer_trusted;
    logic [tpcr_pkg::PREFIX_W-1:0]   prefix_limit;
    tpcr_pkg::t_net                  new_net;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_action      <= i_action;
            r_in_index       <= i_entry_index;
            r_in_entry_valid <= i_entry_valid;
            r_in_v6          <= i_is_v6;
            r_in_addr        <= i_is_v6 ? {i_address_high, i_address_low}
                                        : {96'd0, i_address_low[31:0]};
            r_in_prefix      <= i_prefix_length;
            r_in_last        <= i_last;
        end
    end

    tpcr_lookup #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_lookup (
        .i_net       (r_net),
        .i_net_valid (r_net_valid),
        .i_v6        (r_in_v6),
        .i_addr      (r_in_addr),
        .o_hit       (hit)
    );

    assign prefix_limit = r_in_v6 ? tpcr_pkg::V6_PREFIX_MAX : tpcr_pkg::V4_PREFIX_MAX;
    assign index_in_range = 32'(r_in_index) < TABLE_ENTRIES;

    always_comb begin
        new_net.v6   = r_in_v6;
        new_net.addr = r_in_addr;
        if (r_in_v6) begin
            new_net.mask = ~({tpcr_pkg::ADDR_W{1'b1}} >> r_in_prefix);
        end else begin
            new_net.mask = {96'd0, ~(32'hffff_ffff >> r_in_prefix)};
        end
    end

    always_comb begin
        n_cur_addr         = r_cur_addr;
        n_cur_v6           = r_cur_v6;
        n_walk_active      = r_walk_active;
        n_walk_stopped     = r_walk_stopped;
        n_start_trusted    = r_start_trusted;
        n_hop_count        = r_hop_count;
        load_write         = 1'b0;
        load_clear         = 1'b0;
        close_walk         = 1'b0;
        emit               = 1'b0;
        res_status         = tpcr_pkg::ST_OK;
        res_v6             = 1'b0;
        res_addr           = '0;
        res_used_forwarded = 1'b0;
        res_peer_trusted   = 1'b0;
        case (r_in_action)
            tpcr_pkg::ACT_LOAD: begin
                emit = 1'b1;
                if (index_in_range) begin
                    if (!r_in_entry_valid) begin
                        load_clear = 1'b1;
                    end else if (r_in_prefix > prefix_limit) begin
                        res_status = tpcr_pkg::ST_PREFIX;
                    end else begin
                        load_write = 1'b1;
                    end
                end
            end
            tpcr_pkg::ACT_START: begin
                n_cur_addr      = r_in_addr;
                n_cur_v6        = r_in_v6;
                n_start_trusted = hit;
                n_walk_stopped  = !hit;
                n_hop_count     = '0;
                n_walk_active   = 1'b1;
                close_walk      = r_in_last;
            end
            tpcr_pkg::ACT_HOP: begin
                if (r_walk_active) begin
                    if (r_hop_count <= HOP_LIMIT) begin
                        n_hop_count = r_hop_count + 1'b1;
                    end
                    if (r_start_trusted && !r_walk_stopped) begin
                        n_cur_addr = r_in_addr;
                        n_cur_v6   = r_in_v6;
                        if (!hit) begin
                            n_walk_stopped = 1'b1;
                        end
                    end
                    close_walk = r_in_last;
                end
            end
            default: begin
            end
        endcase
        if (close_walk) begin
            n_walk_active    = 1'b0;
            emit             = 1'b1;
            res_peer_trusted = n_start_trusted;
            if (n_start_trusted && (n_hop_count > HOP_LIMIT)) begin
                res_status = tpcr_pkg::ST_HOPS;
            end else begin
                res_v6             = n_cur_v6;
                res_addr           = n_cur_addr;
                res_used_forwarded = n_start_trusted && (n_hop_count != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_addr      <= '0;
            r_cur_v6        <= 1'b0;
            r_walk_active   <= 1'b0;
            r_walk_stopped  <= 1'b0;
            r_start_trusted <= 1'b0;
            r_hop_count     <= '0;
        end else if (advance) begin
            r_cur_addr      <= n_cur_addr;
            r_cur_v6        <= n_cur_v6;
            r_walk_active   <= n_walk_active;
            r_walk_stopped  <= n_walk_stopped;
            r_start_trusted <= n_start_trusted;
            r_hop_count     <= n_hop_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_valid <= '0;
        end else if (advance) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (32'(r_in_index) == 32'(i)) begin
                    if (load_write) begin
                        r_net_valid[i] <= 1'b1;
                    end else if (load_clear) begin
                        r_net_valid[i] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && load_write) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (32'(r_in_index) == 32'(i)) begin
                    r_net[i] <= new_net;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_status         <= res_status;
            r_out_v6             <= res_v6;
            r_out_addr           <= res_addr;
            r_out_used_forwarded <= res_used_forwarded;
            r_out_peer_trusted   <= res_peer_trusted;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_client_is_v6   = r_out_v6;
    assign o_client_high    = r_out_addr[127:64];
    assign o_client_low     = r_out_addr[63:0];
    assign o_used_forwarded = r_out_used_forwarded;
    assign o_peer_trusted   = r_out_peer_trusted;

    `TPCR_ASSERT_SAME(a_hops_saturate, i_clk, i_rst_n, 1'b1,
                      r_hop_count <= HOP_LIMIT + 1'b1)
    `TPCR_ASSERT_SAME(a_forwarded_needs_trust, i_clk, i_rst_n,
                      r_out_valid && r_out_used_forwarded, r_out_peer_trusted)
    `TPCR_ASSERT_SAME(a_hop_error_form, i_clk, i_rst_n,
                      r_out_valid && (r_out_status == tpcr_pkg::ST_HOPS),
                      r_out_peer_trusted && !r_out_used_forwarded && (r_out_addr == '0))
    `TPCR_ASSERT_NEXT(a_start_opens_walk, i_clk, i_rst_n,
                      advance && (r_in_action == tpcr_pkg::ACT_START) && !r_in_last,
                      r_walk_active && (r_hop_count == '0))

endmodule
